[rtl/nps_pkg.sv]
// Shared types and field widths of the nonpreemptive priority scheduler.
// No dependencies; imported by the top level.
package nps_pkg;

  localparam int PRI_W   = 8;
  localparam int TIME_W  = 16;
  localparam int PIDX_W  = 4;
  localparam int CTIME_W = 21;
  localparam int TOT_W   = 25;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } nps_state_t;

endpackage

[rtl/nps_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/nonpreemptive_priority_scheduler.sv]
// Nonpreemptive priority scheduler, top level. Uses nps_pkg and nps_ram.
// Load: one word per cycle while busy is low; the word with last_process set starts the run.
// Each dispatch scans all n loaded entries through the process RAM read port,
// plus one more scan whenever no process has arrived yet.
// Results then leave one per cycle in load order once the last dispatch is done.
// Reset (rst_n low, synchronous) empties the set and clears all control state.
module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int MAX_PROCESSES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [PRI_W-1:0]   in_priority_req,
  input  logic [TIME_W-1:0]  in_arrival_time,
  input  logic [TIME_W-1:0]  in_burst_time,
  input  logic               in_last_process,
  output logic               out_strobe,
  output logic [PIDX_W-1:0]  out_process_index,
  output logic [PIDX_W-1:0]  out_dispatch_position,
  output logic [CTIME_W-1:0] out_completion_time,
  output logic [CTIME_W-1:0] out_turnaround_time,
  output logic [CTIME_W-1:0] out_waiting_time,
  output logic [TOT_W-1:0]   out_total_turnaround,
  output logic [TOT_W-1:0]   out_total_waiting,
  output logic               out_overflow_flag,
  output logic               out_last_result
);

  localparam int IDX_W  = $clog2(MAX_PROCESSES);
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int CLK_W  = TIME_W + CNT_W;
  localparam int SUM_W  = CLK_W + IDX_W;
  localparam int PROW_W = PRI_W + 2 * TIME_W;
  localparam int RROW_W = CLK_W + IDX_W;

  nps_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         count_r;
  logic                     overflow_r;
  logic [MAX_PROCESSES-1:0] fin_r;
  logic [CLK_W-1:0]         clock_r;
  logic [CNT_W-1:0]         done_r;
  logic [CNT_W-1:0]         iss_r;
  logic                     rd_v_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic                     found_r;
  logic                     any_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [PRI_W-1:0]         best_pri_r;
  logic [TIME_W-1:0]        best_burst_r;
  logic [TIME_W-1:0]        earliest_r;

  // emit pipeline, first stage
  logic                     e_v_r;
  logic                     e_last_r;
  logic [IDX_W-1:0]         e_idx_r;
  logic [IDX_W-1:0]         e_disp_r;
  logic [CLK_W-1:0]         e_comp_r;
  logic [CLK_W-1:0]         e_tat_r;
  logic [TIME_W-1:0]        e_burst_r;

  logic [SUM_W-1:0]         sum_tat_r;
  logic [SUM_W-1:0]         sum_wt_r;

  logic                     strobe_r;
  logic [PIDX_W-1:0]        o_idx_r;
  logic [PIDX_W-1:0]        o_disp_r;
  logic [CTIME_W-1:0]       o_comp_r;
  logic [CTIME_W-1:0]       o_tat_r;
  logic [CTIME_W-1:0]       o_wt_r;
  logic [TOT_W-1:0]         o_ttat_r;
  logic [TOT_W-1:0]         o_twt_r;
  logic                     o_ovf_r;
  logic                     o_last_r;

  logic                     accept;
  logic                     store_en;
  logic                     iss_go;
  logic                     scan_end;
  logic                     last_dispatch;
  logic [IDX_W-1:0]         raddr;
  logic [PROW_W-1:0]        prow;
  logic [RROW_W-1:0]        rrow;
  logic [PRI_W-1:0]         p_pri;
  logic [TIME_W-1:0]        p_arr;
  logic [TIME_W-1:0]        p_burst;
  logic                     entry_open;
  logic                     entry_ready;
  logic [CLK_W-1:0]         clock_done;
  logic [CLK_W-1:0]         wt_now;
  logic [SUM_W-1:0]         sum_tat_nxt;
  logic [SUM_W-1:0]         sum_wt_nxt;

  assign busy      = (state_r != ST_LOAD);
  assign accept    = start && !busy;
  assign store_en  = accept && (count_r < CNT_W'(MAX_PROCESSES));
  assign iss_go    = ((state_r == ST_SCAN) || (state_r == ST_EMIT)) && (iss_r < count_r);
  assign raddr     = iss_r[IDX_W-1:0];
  assign scan_end  = (iss_r == count_r) && !rd_v_r;
  assign last_dispatch = found_r && ((done_r + CNT_W'(1)) == count_r);
  assign clock_done    = clock_r + CLK_W'(best_burst_r);

  assign p_pri   = prow[PROW_W-1 -: PRI_W];
  assign p_arr   = prow[2*TIME_W-1 -: TIME_W];
  assign p_burst = prow[TIME_W-1:0];

  assign entry_open  = !fin_r[rd_idx_r];
  assign entry_ready = entry_open && (CLK_W'(p_arr) <= clock_r);

  assign wt_now      = e_tat_r - CLK_W'(e_burst_r);
  assign sum_tat_nxt = sum_tat_r + SUM_W'(e_tat_r);
  assign sum_wt_nxt  = sum_wt_r + SUM_W'(wt_now);

  // process table: {priority, arrival, burst}
  nps_ram #(
    .WIDTH (PROW_W),
    .DEPTH (MAX_PROCESSES)
  ) u_proc_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({in_priority_req, in_arrival_time, in_burst_time}),
    .raddr (raddr),
    .rdata (prow)
  );

  // result table: {completion, dispatch position}; written at dispatch, its read data used only in emit
  nps_ram #(
    .WIDTH (RROW_W),
    .DEPTH (MAX_PROCESSES)
  ) u_res_ram (
    .clk   (clk),
    .we    ((state_r == ST_DECIDE) && found_r),
    .waddr (best_idx_r),
    .wdata ({clock_done, done_r[IDX_W-1:0]}),
    .raddr (raddr),
    .rdata (rrow)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_last_process) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = last_dispatch ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: begin
        if (e_v_r && e_last_r) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
      fin_r      <= '0;
      clock_r    <= '0;
      done_r     <= '0;
      iss_r      <= '0;
      rd_v_r     <= 1'b0;
      found_r    <= 1'b0;
      any_r      <= 1'b0;
      e_v_r      <= 1'b0;
      sum_tat_r  <= '0;
      sum_wt_r   <= '0;
      strobe_r   <= 1'b0;
    end else begin
      rd_v_r   <= iss_go;
      e_v_r    <= rd_v_r && (state_r == ST_EMIT);
      strobe_r <= e_v_r;
      if (iss_go) iss_r <= iss_r + CNT_W'(1);

      if (accept) begin
        if (store_en) count_r <= count_r + CNT_W'(1);
        else          overflow_r <= 1'b1;
        iss_r   <= '0;
        found_r <= 1'b0;
        any_r   <= 1'b0;
      end

      if ((state_r == ST_SCAN) && rd_v_r) begin
        if (entry_ready && (!found_r || (p_pri > best_pri_r))) found_r <= 1'b1;
        if (entry_open) any_r <= 1'b1;
      end

      if (state_r == ST_DECIDE) begin
        iss_r   <= '0;
        found_r <= 1'b0;
        any_r   <= 1'b0;
        if (found_r) begin
          clock_r            <= clock_done;
          fin_r[best_idx_r]  <= 1'b1;
          done_r             <= done_r + CNT_W'(1);
        end else begin
          // nothing has arrived: jump to the earliest open arrival
          clock_r <= CLK_W'(earliest_r);
        end
      end

      if (e_v_r) begin
        if (e_last_r) begin
          count_r    <= '0;
          overflow_r <= 1'b0;
          fin_r      <= '0;
          clock_r    <= '0;
          done_r     <= '0;
          sum_tat_r  <= '0;
          sum_wt_r   <= '0;
        end else begin
          sum_tat_r <= sum_tat_nxt;
          sum_wt_r  <= sum_wt_nxt;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_idx_r <= raddr;

    if ((state_r == ST_SCAN) && rd_v_r) begin
      if (entry_ready && (!found_r || (p_pri > best_pri_r))) begin
        best_idx_r   <= rd_idx_r;
        best_pri_r   <= p_pri;
        best_burst_r <= p_burst;
      end
      if (entry_open && (!any_r || (p_arr < earliest_r))) begin
        earliest_r <= p_arr;
      end
    end

    e_idx_r   <= rd_idx_r;
    e_last_r  <= (CNT_W'(rd_idx_r) == (count_r - CNT_W'(1)));
    e_disp_r  <= rrow[IDX_W-1:0];
    e_comp_r  <= rrow[RROW_W-1 -: CLK_W];
    e_tat_r   <= rrow[RROW_W-1 -: CLK_W] - CLK_W'(p_arr);
    e_burst_r <= p_burst;

    o_idx_r  <= PIDX_W'(e_idx_r);
    o_disp_r <= PIDX_W'(e_disp_r);
    o_comp_r <= CTIME_W'(e_comp_r);
    o_tat_r  <= CTIME_W'(e_tat_r);
    o_wt_r   <= CTIME_W'(wt_now);
    o_ttat_r <= e_last_r ? TOT_W'(sum_tat_nxt) : '0;
    o_twt_r  <= e_last_r ? TOT_W'(sum_wt_nxt) : '0;
    o_ovf_r  <= overflow_r;
    o_last_r <= e_last_r;
  end

  assign out_strobe            = strobe_r;
  assign out_process_index     = o_idx_r;
  assign out_dispatch_position = o_disp_r;
  assign out_completion_time   = o_comp_r;
  assign out_turnaround_time   = o_tat_r;
  assign out_waiting_time      = o_wt_r;
  assign out_total_turnaround  = o_ttat_r;
  assign out_total_waiting     = o_twt_r;
  assign out_overflow_flag     = o_ovf_r;
  assign out_last_result       = o_last_r && strobe_r;

  // every finished mark belongs to exactly one dispatch
  a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(fin_r) == 32'(done_r))
    else $error("finished marks disagree with dispatch count");

  // a scan without a ready process must have seen an open one
  a_idle_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) && !found_r |-> any_r)
    else $error("idle jump with no open process");

  // results only come out of the emit phase
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    e_v_r |-> state_r == ST_EMIT)
    else $error("result word outside emit phase");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PROCESSES))
    else $error("loaded count past table depth");

  // the run ends right after its last word
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> state_r == ST_LOAD && count_r == '0)
    else $error("set not cleared after last result");

endmodule

[bench/nonpreemptive_priority_scheduler_tb.sv]
// Self-checking bench for nonpreemptive_priority_scheduler: directed sets, then random sets
// under several sender idle rates. Depends on nps_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_tb;
  import nps_pkg::*;

  localparam int NPROC = 16;

  typedef struct {
    logic [PIDX_W-1:0]  idx;
    logic [PIDX_W-1:0]  disp;
    logic [CTIME_W-1:0] compl;
    logic [CTIME_W-1:0] tat;
    logic [CTIME_W-1:0] wt;
    logic [TOT_W-1:0]   tot_tat;
    logic [TOT_W-1:0]   tot_wt;
    logic               ovf;
    logic               last;
  } report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [PRI_W-1:0]   in_priority_req = '0;
  logic [TIME_W-1:0]  in_arrival_time = '0;
  logic [TIME_W-1:0]  in_burst_time = '0;
  logic               in_last_process = 1'b0;
  logic               out_strobe;
  logic [PIDX_W-1:0]  out_process_index;
  logic [PIDX_W-1:0]  out_dispatch_position;
  logic [CTIME_W-1:0] out_completion_time;
  logic [CTIME_W-1:0] out_turnaround_time;
  logic [CTIME_W-1:0] out_waiting_time;
  logic [TOT_W-1:0]   out_total_turnaround;
  logic [TOT_W-1:0]   out_total_waiting;
  logic               out_overflow_flag;
  logic               out_last_result;

  // predictor copy of the process set being loaded
  logic [PRI_W-1:0]  pri_tab[NPROC];
  logic [TIME_W-1:0] arr_tab[NPROC];
  logic [TIME_W-1:0] burst_tab[NPROC];
  int                held = 0;
  bit                dropped_seen = 1'b0;

  report_t due_reports[$];
  int      err_count = 0;
  int      words_sent = 0;
  int      sets_run = 0;
  int      results_checked = 0;
  int      idle_pct = 0;

  nonpreemptive_priority_scheduler #(.MAX_PROCESSES(NPROC)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_priority_req      (in_priority_req),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .in_last_process      (in_last_process),
    .out_strobe           (out_strobe),
    .out_process_index    (out_process_index),
    .out_dispatch_position(out_dispatch_position),
    .out_completion_time  (out_completion_time),
    .out_turnaround_time  (out_turnaround_time),
    .out_waiting_time     (out_waiting_time),
    .out_total_turnaround (out_total_turnaround),
    .out_total_waiting    (out_total_waiting),
    .out_overflow_flag    (out_overflow_flag),
    .out_last_result      (out_last_result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d result words outstanding", due_reports.size());
    $display("[nonpreemptive_priority_scheduler] ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [TOT_W-1:0] got,
                             input logic [TOT_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                              results_checked, name, got, want));
  endtask

  // Store one process; on the last mark run the schedule and queue the per-process reports.
  task automatic take_word(input logic [PRI_W-1:0] p, input logic [TIME_W-1:0] a,
                           input logic [TIME_W-1:0] b, input logic lst);
    longint unsigned now, earliest, tat, wt, sum_tat, sum_wt;
    longint unsigned fin[NPROC];
    int              order[NPROC];
    bit              done[NPROC];
    bit              found;
    int              best, ndone, k;
    report_t         r;
    if (held < NPROC) begin
      pri_tab[held] = p;
      arr_tab[held] = a;
      burst_tab[held] = b;
      held++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!lst) return;

    now = 0;
    ndone = 0;
    for (k = 0; k < NPROC; k++) done[k] = 1'b0;
    while (ndone < held) begin
      found = 1'b0;
      best = 0;
      for (k = 0; k < held; k++)
        if (!done[k] && arr_tab[k] <= now && (!found || pri_tab[k] > pri_tab[best])) begin
          found = 1'b1;
          best = k;
        end
      if (!found) begin
        // nothing ready: jump to the earliest pending arrival
        earliest = '1;
        for (k = 0; k < held; k++)
          if (!done[k] && arr_tab[k] < earliest) earliest = arr_tab[k];
        now = earliest;
      end else begin
        now += burst_tab[best];
        fin[best] = now;
        order[best] = ndone;
        done[best] = 1'b1;
        ndone++;
      end
    end

    sum_tat = 0;
    sum_wt = 0;
    for (k = 0; k < held; k++) begin
      tat = fin[k] - arr_tab[k];
      wt = tat - burst_tab[k];
      sum_tat += tat;
      sum_wt += wt;
      r.idx = PIDX_W'(k);
      r.disp = PIDX_W'(order[k]);
      r.compl = CTIME_W'(fin[k]);
      r.tat = CTIME_W'(tat);
      r.wt = CTIME_W'(wt);
      r.last = (k == held - 1);
      r.tot_tat = r.last ? TOT_W'(sum_tat) : '0;
      r.tot_wt = r.last ? TOT_W'(sum_wt) : '0;
      r.ovf = dropped_seen;
      due_reports.push_back(r);
    end
    held = 0;
    dropped_seen = 1'b0;
    sets_run++;
  endtask

  // Offer one word and hold it until the block takes it; start stays high afterwards.
  task automatic send_word(input logic [PRI_W-1:0] p, input logic [TIME_W-1:0] a,
                           input logic [TIME_W-1:0] b, input logic lst);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_priority_req <= p;
    in_arrival_time <= a;
    in_burst_time <= b;
    in_last_process <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    take_word(p, a, b, lst);
    words_sent++;
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_strobe) begin
      if (due_reports.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        want = due_reports.pop_front();
        check_field("process_index", out_process_index, want.idx);
        check_field("dispatch_position", out_dispatch_position, want.disp);
        check_field("completion_time", out_completion_time, want.compl);
        check_field("turnaround_time", out_turnaround_time, want.tat);
        check_field("waiting_time", out_waiting_time, want.wt);
        check_field("total_turnaround", out_total_turnaround, want.tot_tat);
        check_field("total_waiting", out_total_waiting, want.tot_wt);
        check_field("overflow_flag", out_overflow_flag, want.ovf);
        check_field("last_result", out_last_result, want.last);
        results_checked++;
      end
    end
  end

  // single-process sets at both ends of every field
  task automatic test_extremes();
    send_word(8'hff, 16'hffff, 16'hffff, 1'b1);
    send_word(8'h00, 16'h0000, 16'h0000, 1'b1);
  endtask

  // three priority-zero processes arrive at once and ties go to the lower load index; zero bursts too
  task automatic test_zero_priority_ties();
    send_word(8'h00, 16'd0, 16'd0, 1'b0);
    send_word(8'h00, 16'd0, 16'd7, 1'b0);
    send_word(8'h00, 16'd0, 16'd0, 1'b0);
    send_word(8'h01, 16'd3, 16'd2, 1'b1);
  endtask

  // nothing ready at times 0, 13 and 105: the clock must jump forward each time
  task automatic test_idle_jumps();
    send_word(8'd1, 16'd100, 16'd5, 1'b0);
    send_word(8'd0, 16'd10, 16'd3, 1'b0);
    send_word(8'd9, 16'd200, 16'd0, 1'b1);
  endtask

  // full set at maximum times, then two dropped words, the second carrying the last mark
  task automatic test_overflow_full();
    int k;
    for (k = 0; k < NPROC; k++)
      send_word(PRI_W'(k * 17), 16'hffff, 16'hffff, 1'b0);
    send_word(8'h5a, 16'h1234, 16'h0042, 1'b0);
    send_word(8'ha5, 16'h0001, 16'h0001, 1'b1);
  endtask

  function automatic logic [TIME_W-1:0] pick_time(input int mode);
    case (mode)
      0:       return TIME_W'($urandom_range(0, 40));
      1:       return TIME_W'($urandom_range(0, 400));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  task automatic test_random_sets(input int pct, input int nwords);
    int target, sz, k, roll, amode, bmode;
    bit pwide;
    idle_pct = pct;
    target = words_sent + nwords;
    while (words_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 75)      sz = $urandom_range(1, 6);
      else if (roll < 94) sz = $urandom_range(7, NPROC);
      else                sz = $urandom_range(NPROC + 1, NPROC + 3);
      amode = $urandom_range(2);
      bmode = $urandom_range(2);
      pwide = $urandom_range(1);
      for (k = 0; k < sz; k++)
        send_word(pwide ? PRI_W'($urandom) : PRI_W'($urandom_range(3)),
                  pick_time(amode), pick_time(bmode), k == sz - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_zero_priority_ties();
    test_idle_jumps();
    test_overflow_full();
    test_random_sets(0, 40);
    test_random_sets(54, 40);
    test_random_sets(27, 40);

    start <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Ran %0d process sets from %0d words; %0d result words checked,",
             sets_run, words_sent, results_checked);
    $display("sender idle at 0, 54 and 27 percent; %0d mismatches", err_count);
    if (err_count == 0)
      $display("[nonpreemptive_priority_scheduler] OK");
    else
      $display("[nonpreemptive_priority_scheduler] ERROR");
    $finish;
  end

endmodule

[nonpreemptive_priority_scheduler.f]
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nonpreemptive_priority_scheduler.sv
bench/nonpreemptive_priority_scheduler_tb.sv
